/* hw/rtl/rbm_pkg.sv */
// Package for the block RMS level meter: sizes, register indexes and the
// job word that the sample front end hands to the divide/square-root back end.
// No dependencies.
package rbm_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_BLOCK    = 4096;
    localparam int SAMPLE_BITS  = 24;

    // samples in a block before the tally saturates
    localparam int TALLY_LIMIT = MAX_CHANNELS * MAX_BLOCK;
    localparam int TALLY_W     = $clog2(TALLY_LIMIT + 1);

    // square of a magnitude is at most 2^(2*SAMPLE_BITS-2)
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = SQ_W + TALLY_W - 1;
    localparam int MEAN_W = SQ_W;
    localparam int ROOT_W = SAMPLE_BITS;

    // configuration registers
    localparam int CC_W      = 4;
    localparam int BL_W      = 13;
    localparam int EXP_W     = CC_W + BL_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH  = 1'd1;

    localparam logic [CC_W-1:0] CC_RESET = 4'd2;
    localparam logic [BL_W-1:0] BL_RESET = 13'd512;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [TALLY_W-1:0] tally;
        logic               mismatch;
    } job_t;

endpackage

/* hw/rtl/rbm_front.sv */
// Sample front end: config registers, magnitude, square, accumulate, tally.
// Pushes one job_t per block end. Depends on rbm_pkg.
module rbm_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rbm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rbm_pkg::CFG_DAT_W-1:0]         cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [rbm_pkg::SAMPLE_BITS-1:0] s_sample_value,
    input  logic                                  s_last_of_block,
    input  logic                                  job_full,
    output logic                                  job_push,
    output rbm_pkg::job_t                         job_data
);

    logic [rbm_pkg::CC_W-1:0]    cc_reg;
    logic [rbm_pkg::BL_W-1:0]    bl_reg;
    logic [rbm_pkg::EXP_W-1:0]   expected;

    logic [rbm_pkg::TALLY_W-1:0] tally_reg, tally_next, tally_inc;
    logic                        ovf_reg, ovf_next, ovf_inc;
    logic                        add_ok, mis_now, accept, advance;
    logic [rbm_pkg::SAMPLE_BITS-1:0] mag;

    // stage A: magnitude
    logic                            a_valid_reg;
    logic [rbm_pkg::SAMPLE_BITS-1:0] a_mag_reg;
    logic                            a_last_reg, a_add_reg, a_mis_reg;
    logic [rbm_pkg::TALLY_W-1:0]     a_tally_reg;
    // stage B: square
    logic                            b_valid_reg;
    logic [rbm_pkg::SQ_W-1:0]        b_sq_reg;
    logic                            b_last_reg, b_add_reg, b_mis_reg;
    logic [rbm_pkg::TALLY_W-1:0]     b_tally_reg;
    logic [2*rbm_pkg::SAMPLE_BITS-1:0] prod;

    logic [rbm_pkg::SUM_W-1:0]       sum_reg, sum_plus;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg <= rbm_pkg::CC_RESET;
            bl_reg <= rbm_pkg::BL_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                rbm_pkg::REG_CHANNEL_COUNT: cc_reg <= cfg_data[rbm_pkg::CC_W-1:0];
                rbm_pkg::REG_BLOCK_LENGTH:  bl_reg <= cfg_data[rbm_pkg::BL_W-1:0];
                default: ;
            endcase
        end
    end

    assign expected = rbm_pkg::EXP_W'(cc_reg) * rbm_pkg::EXP_W'(bl_reg);

    // the whole pipe holds while a block end waits for queue room
    assign advance  = !(b_valid_reg && b_last_reg && job_full);
    assign s_ready  = advance;
    assign accept   = s_valid && s_ready;

    assign mag = s_sample_value[rbm_pkg::SAMPLE_BITS-1] ?
                 (~s_sample_value + 1'b1) : s_sample_value;

    always_comb begin
        add_ok    = tally_reg < rbm_pkg::TALLY_W'(rbm_pkg::TALLY_LIMIT);
        tally_inc = add_ok ? tally_reg + 1'b1 : tally_reg;
        ovf_inc   = ovf_reg | !add_ok;
        mis_now   = ovf_inc || (32'(tally_inc) != 32'(expected)) || (tally_inc == '0);
        tally_next = tally_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            tally_next = s_last_of_block ? '0 : tally_inc;
            ovf_next   = s_last_of_block ? 1'b0 : ovf_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tally_reg   <= '0;
            ovf_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            sum_reg     <= '0;
        end else begin
            tally_reg <= tally_next;
            ovf_reg   <= ovf_next;
            if (advance) begin
                a_valid_reg <= accept;
                b_valid_reg <= a_valid_reg;
                if (b_valid_reg) begin
                    if (b_last_reg)
                        sum_reg <= '0;
                    else
                        sum_reg <= sum_plus;
                end
            end
        end
    end

    assign prod = a_mag_reg * a_mag_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (accept) begin
                a_mag_reg   <= mag;
                a_last_reg  <= s_last_of_block;
                a_add_reg   <= add_ok;
                a_mis_reg   <= mis_now;
                a_tally_reg <= tally_inc;
            end
            b_sq_reg    <= prod[rbm_pkg::SQ_W-1:0];
            b_last_reg  <= a_last_reg;
            b_add_reg   <= a_add_reg;
            b_mis_reg   <= a_mis_reg;
            b_tally_reg <= a_tally_reg;
        end
    end

    assign sum_plus = b_add_reg ? sum_reg + rbm_pkg::SUM_W'(b_sq_reg) : sum_reg;

    assign job_push          = advance && b_valid_reg && b_last_reg;
    assign job_data.sum      = sum_plus;
    assign job_data.tally    = b_tally_reg;
    assign job_data.mismatch = b_mis_reg;

endmodule

/* hw/rtl/rbm_job_fifo.sv */
// Short queue of block-end jobs between front end and back end.
// Depends on rbm_pkg.
module rbm_job_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rbm_pkg::job_t push_data,
    input  logic          pop,
    output rbm_pkg::job_t pop_data,
    output logic          full,
    output logic          empty
);

    rbm_pkg::job_t mem [rbm_pkg::FIFO_DEPTH];
    logic [rbm_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [rbm_pkg::FIFO_AW:0]   count_reg;

    assign full     = count_reg == (rbm_pkg::FIFO_AW+1)'(rbm_pkg::FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

/* hw/rtl/rbm_back.sv */
// Back end: bit-serial mean (sum / tally), digit-by-digit square root,
// max/min bound update and the result register. Depends on rbm_pkg.
module rbm_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            job_empty,
    output logic                            job_pop,
    input  rbm_pkg::job_t                   job_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rbm_pkg::ROOT_W-1:0]      m_rms_level,
    output logic [rbm_pkg::ROOT_W-1:0]      m_max_level,
    output logic [rbm_pkg::ROOT_W-1:0]      m_min_level,
    output logic                            m_size_mismatch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int CNT_W  = $clog2(rbm_pkg::SUM_W);
    localparam int RAD_W  = 2 * rbm_pkg::ROOT_W;
    localparam int SREM_W = rbm_pkg::ROOT_W + 3;

    logic [1:0]                    state_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [rbm_pkg::SUM_W-1:0]     dvd_reg;
    logic [rbm_pkg::TALLY_W-1:0]   rem_reg, dvs_reg;
    logic                          mis_reg;
    logic [RAD_W-1:0]              rad_reg;
    logic [SREM_W-1:0]             srem_reg;
    logic [rbm_pkg::ROOT_W-1:0]    root_reg;
    logic [rbm_pkg::ROOT_W-1:0]    max_reg, min_reg, max_next, min_next;

    logic                          m_valid_reg, m_mis_reg;
    logic [rbm_pkg::ROOT_W-1:0]    m_rms_reg, m_max_reg, m_min_reg;

    logic [rbm_pkg::TALLY_W:0]     rem_sh, rem_dif;
    logic                          div_ge;
    logic [SREM_W-1:0]             srem_sh, trial, srem_dif;
    logic                          sq_ge;
    logic                          out_free;

    assign job_pop  = (state_reg == ST_IDLE) && !job_empty;
    assign out_free = !m_valid_reg || m_ready;

    // restoring divide, one quotient bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[rbm_pkg::SUM_W-1]};
    assign rem_dif = rem_sh - {1'b0, dvs_reg};
    assign div_ge  = !rem_dif[rbm_pkg::TALLY_W];

    // square root, one result bit per cycle
    assign srem_sh  = {srem_reg[SREM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign srem_dif = srem_sh - trial;
    assign sq_ge    = srem_sh >= trial;

    always_comb begin
        max_next = (root_reg > max_reg) ? root_reg : max_reg;
        min_next = (root_reg < min_reg) ? root_reg : min_reg;
        if (root_reg == '0) begin
            max_next = '0;
            min_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            max_reg     <= '0;
            min_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (!job_empty)
                        state_reg <= job_data.mismatch ? ST_DONE : ST_DIV;
                end
                ST_DIV: begin
                    if (cnt_reg == '0)
                        state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (cnt_reg == '0)
                        state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        max_reg     <= max_next;
                        min_reg     <= min_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                dvd_reg  <= job_data.sum;
                dvs_reg  <= job_data.tally;
                mis_reg  <= job_data.mismatch;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(rbm_pkg::SUM_W - 1);
            end
            ST_DIV: begin
                rem_reg <= div_ge ? rem_dif[rbm_pkg::TALLY_W-1:0]
                                  : rem_sh[rbm_pkg::TALLY_W-1:0];
                dvd_reg <= {dvd_reg[rbm_pkg::SUM_W-2:0], div_ge};
                if (cnt_reg == '0) begin
                    rad_reg  <= RAD_W'({dvd_reg[rbm_pkg::SUM_W-2:0], div_ge});
                    srem_reg <= '0;
                    root_reg <= '0;
                    cnt_reg  <= CNT_W'(rbm_pkg::ROOT_W - 1);
                end else begin
                    cnt_reg  <= cnt_reg - 1'b1;
                end
            end
            ST_SQRT: begin
                srem_reg <= sq_ge ? srem_dif : srem_sh;
                root_reg <= {root_reg[rbm_pkg::ROOT_W-2:0], sq_ge};
                rad_reg  <= rad_reg << 2;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_rms_reg <= root_reg;
                    m_max_reg <= max_next;
                    m_min_reg <= min_next;
                    m_mis_reg <= mis_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_rms_level     = m_rms_reg;
    assign m_max_level     = m_max_reg;
    assign m_min_level     = m_min_reg;
    assign m_size_mismatch = m_mis_reg;

endmodule

/* hw/rtl/rms_block_level_meter.sv */
// Top level of the block RMS level meter.
// Instantiates rbm_front, rbm_job_fifo and rbm_back; uses rbm_pkg.

// Samples stream in at one per cycle: s_ready stays high unless a block end
// finds the four-entry job queue full. Each sample is squared and summed;
// the sample flagged last_of_block closes the block and queues a job. The
// back end then takes each job through a bit-serial divide (sum / count)
// and a square root in a single shared divide/root sequencer, and pops no
// new job until the last result is registered. Blocks shorter than that work
// fill the queue and then throttle the input. A block whose sample count is
// not channel_count*block_length (or exceeds 32768 samples) reports RMS 0
// with size_mismatch set; an RMS of 0 also clears the max/min bounds.
// Config (cfg_index 0 = channel_count, 1 = block_length) is always ready
// and must only be written while the meter is idle.
module rms_block_level_meter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // config write
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rbm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rbm_pkg::CFG_DAT_W-1:0]          cfg_data,
    // sample stream
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [rbm_pkg::SAMPLE_BITS-1:0] s_sample_value,
    input  logic                                   s_last_of_block,
    // per-block result
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [rbm_pkg::ROOT_W-1:0]             m_rms_level,
    output logic [rbm_pkg::ROOT_W-1:0]             m_max_level,
    output logic [rbm_pkg::ROOT_W-1:0]             m_min_level,
    output logic                                   m_size_mismatch
);

    // job word: block sum, sample count and the mismatch verdict
    rbm_pkg::job_t push_word, pop_word;
    logic          job_push, job_pop, job_full, job_empty;

    // front: config regs, |x|, x^2 (one multiplier), accumulate and tally
    rbm_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_value  (s_sample_value),
        .s_last_of_block (s_last_of_block),
        .job_full        (job_full),
        .job_push        (job_push),
        .job_data        (push_word)
    );

    // decouples sample intake from the slow per-block math
    rbm_job_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (push_word),
        .pop       (job_pop),
        .pop_data  (pop_word),
        .full      (job_full),
        .empty     (job_empty)
    );

    // back: divide, sqrt, bounds, registered result
    rbm_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_empty       (job_empty),
        .job_pop         (job_pop),
        .job_data        (pop_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rms_level     (m_rms_level),
        .m_max_level     (m_max_level),
        .m_min_level     (m_min_level),
        .m_size_mismatch (m_size_mismatch)
    );

endmodule
